### rtl/tab_pkg.sv
// Shared types, constants and register codes for the transformed bounding box block.
`timescale 1ns / 1ps
`default_nettype none
package tab_pkg;

   localparam int NumAxes  = 3;
   localparam int CoordW   = 32;
   localparam int CoefW    = 16;
   localparam int RowW     = NumAxes * CoefW;
   localparam int MarginW  = 21;
   localparam int ProdW    = CoefW + CoordW;
   localparam int FracDrop = 14;
   localparam int SumW     = ProdW + 2;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = RowW;

   localparam logic [RowW-1:0]    RowXReset   = 48'h0000_0000_4000;
   localparam logic [RowW-1:0]    RowYReset   = 48'h0000_4000_0000;
   localparam logic [RowW-1:0]    RowZReset   = 48'h4000_0000_0000;
   localparam logic [MarginW-1:0] MarginReset = 21'd6554;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROW_X  = 3'd0,
      CSR_ROW_Y  = 3'd1,
      CSR_ROW_Z  = 3'd2,
      CSR_OFS_X  = 3'd3,
      CSR_OFS_Y  = 3'd4,
      CSR_OFS_Z  = 3'd5,
      CSR_MARGIN = 3'd6
   } csr_index_type;

   // transform setup: one coefficient row and one offset per output axis
   typedef struct packed {
      logic [NumAxes-1:0][RowW-1:0]   row;
      logic [NumAxes-1:0][CoordW-1:0] offset;
   } xf_cfg_type;

   // transformed point handed to the bounds tracker
   typedef struct packed {
      logic                           valid;
      logic                           last;
      logic [NumAxes-1:0][CoordW-1:0] point;
   } xf_out_type;

endpackage
`default_nettype wire

### rtl/tab_csr.sv
// Configuration register file: matrix rows, translation and margin.
`timescale 1ns / 1ps
`default_nettype none
module tab_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tab_pkg::CsrIdxW-1:0]      csr_index,
   input  wire logic [tab_pkg::CsrDataW-1:0]     csr_wdata,
   output tab_pkg::xf_cfg_type                   xf_cfg,
   output logic [tab_pkg::MarginW-1:0]           margin
);

   tab_pkg::xf_cfg_type                 cfg_ff;
   logic [tab_pkg::MarginW-1:0]         margin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row[0]    <= tab_pkg::RowXReset;
         cfg_ff.row[1]    <= tab_pkg::RowYReset;
         cfg_ff.row[2]    <= tab_pkg::RowZReset;
         cfg_ff.offset    <= '0;
         margin_ff        <= tab_pkg::MarginReset;
      end else if (csr_valid) begin
         unique case (tab_pkg::csr_index_type'(csr_index))
            tab_pkg::CSR_ROW_X:  cfg_ff.row[0]    <= csr_wdata;
            tab_pkg::CSR_ROW_Y:  cfg_ff.row[1]    <= csr_wdata;
            tab_pkg::CSR_ROW_Z:  cfg_ff.row[2]    <= csr_wdata;
            tab_pkg::CSR_OFS_X:  cfg_ff.offset[0] <= csr_wdata[tab_pkg::CoordW-1:0];
            tab_pkg::CSR_OFS_Y:  cfg_ff.offset[1] <= csr_wdata[tab_pkg::CoordW-1:0];
            tab_pkg::CSR_OFS_Z:  cfg_ff.offset[2] <= csr_wdata[tab_pkg::CoordW-1:0];
            tab_pkg::CSR_MARGIN: margin_ff        <= csr_wdata[tab_pkg::MarginW-1:0];
            default: ;  // unused index, dropped
         endcase
      end
   end

   assign xf_cfg = cfg_ff;
   assign margin = margin_ff;

endmodule
`default_nettype wire

### rtl/tab_xform.sv
// Affine transform pipeline: input register, product register, rounded point register.
`timescale 1ns / 1ps
`default_nettype none
module tab_xform (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              advance,
   input  wire logic                                              in_valid,
   input  wire logic                                              in_last,
   input  wire logic [tab_pkg::NumAxes-1:0][tab_pkg::CoordW-1:0]  in_vertex,
   input  wire tab_pkg::xf_cfg_type                               xf_cfg,
   output tab_pkg::xf_out_type                                    xf_out
);

   localparam int NA = tab_pkg::NumAxes;
   localparam int CW = tab_pkg::CoordW;
   localparam int KW = tab_pkg::CoefW;
   localparam int PW = tab_pkg::ProdW;
   localparam int SW = tab_pkg::SumW;
   localparam int FD = tab_pkg::FracDrop;

   // stage 0: captured vertex
   logic                      s0_valid_ff, s0_last_ff;
   logic [NA-1:0][CW-1:0]     vert_ff;
   // stage 1: nine products
   logic                      s1_valid_ff, s1_last_ff;
   logic signed [PW-1:0]      prod_ff [NA][NA];
   logic signed [PW-1:0]      prod_in [NA][NA];
   // stage 2: rounded, saturated point
   logic                      s2_valid_ff, s2_last_ff;
   logic [NA-1:0][CW-1:0]     point_ff;
   logic [NA-1:0][CW-1:0]     point_in;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int k = 0; k < NA; k++) begin
            prod_in[a][k] = $signed(xf_cfg.row[a][k*KW +: KW]) * $signed(vert_ff[k]);
         end
      end
   end

   // sum, add scaled offset, round half up, drop 14 fraction bits, saturate
   always_comb begin
      logic signed [SW-1:0]    acc;
      logic signed [SW-FD-1:0] shr;
      for (int a = 0; a < NA; a++) begin
         acc = SW'(prod_ff[a][0]) + SW'(prod_ff[a][1]) + SW'(prod_ff[a][2])
             + (SW'($signed(xf_cfg.offset[a])) <<< FD)
             + SW'(1 << (FD - 1));
         shr = acc[SW-1:FD];
         if (shr[SW-FD-1:CW-1] == '0 || shr[SW-FD-1:CW-1] == '1) begin
            point_in[a] = shr[CW-1:0];
         end else begin
            point_in[a] = {shr[SW-FD-1], {(CW-1){~shr[SW-FD-1]}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_last_ff <= in_last;
         vert_ff    <= in_vertex;
         s1_last_ff <= s0_last_ff;
         prod_ff    <= prod_in;
         s2_last_ff <= s1_last_ff;
         point_ff   <= point_in;
      end
   end

   assign xf_out.valid = s2_valid_ff;
   assign xf_out.last  = s2_last_ff;
   assign xf_out.point = point_ff;

endmodule
`default_nettype wire

### rtl/tab_bounds.sv
// Running per-axis min/max tracker and margin-widened result register.
`timescale 1ns / 1ps
`default_nettype none
module tab_bounds (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire tab_pkg::xf_out_type                               xf_out,
   input  wire logic [tab_pkg::MarginW-1:0]                       margin,
   output logic                                                   advance,
   output logic                                                   rsp_valid,
   input  wire logic                                              rsp_ready,
   output logic [tab_pkg::NumAxes-1:0][tab_pkg::CoordW-1:0]       upper,
   output logic [tab_pkg::NumAxes-1:0][tab_pkg::CoordW-1:0]       lower
);

   localparam int NA = tab_pkg::NumAxes;
   localparam int CW = tab_pkg::CoordW;
   localparam int MW = tab_pkg::MarginW;
   localparam logic [CW-1:0] MinVal = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] MaxVal = {1'b0, {(CW-1){1'b1}}};

   logic [NA-1:0][CW-1:0]  max_ff, min_ff, max_in, min_in;
   logic [NA-1:0][CW-1:0]  upper_ff, lower_ff, upper_in, lower_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   take, load;

   function automatic logic [CW-1:0] sat_narrow(input logic [CW:0] v);
      if (v[CW] != v[CW-1]) begin
         sat_narrow = {v[CW], {(CW-1){~v[CW]}}};
      end else begin
         sat_narrow = v[CW-1:0];
      end
   endfunction

   // only a final vertex needs the result register free
   assign advance = !(xf_out.valid && xf_out.last && rsp_valid_ff && !rsp_ready);
   assign take    = advance && xf_out.valid;
   assign load    = take && xf_out.last;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         max_in[a] = ($signed(xf_out.point[a]) > $signed(max_ff[a])) ? xf_out.point[a]
                                                                       : max_ff[a];
         min_in[a] = ($signed(xf_out.point[a]) < $signed(min_ff[a])) ? xf_out.point[a]
                                                                       : min_ff[a];
         upper_in[a] = sat_narrow({max_in[a][CW-1], max_in[a]} + {{(CW+1-MW){1'b0}}, margin});
         lower_in[a] = sat_narrow({min_in[a][CW-1], min_in[a]} - {{(CW+1-MW){1'b0}}, margin});
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_ff       <= {NA{MinVal}};
         min_ff       <= {NA{MaxVal}};
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            max_ff <= {NA{MinVal}};
            min_ff <= {NA{MaxVal}};
         end else if (take) begin
            max_ff <= max_in;
            min_ff <= min_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign upper     = upper_ff;
   assign lower     = lower_ff;

endmodule
`default_nettype wire

### rtl/transformed_aabb_bounds.sv
// Top level: axis-aligned bounding box of affine-transformed vertex runs.
//
// Usage:
//  - req_* carries one vertex per word (x, y, z in Q16.16); req_tlast marks
//    the final vertex of a shape. One vertex is taken per cycle while req_tready is high.
//  - Each vertex goes through x' = M * v + t (M in Q2.14, t in Q16.16),
//    rounded to nearest and saturated to 32 bits, and folds into running
//    per-axis min/max registers.
//  - On the last vertex one rsp_* word comes out: max + margin and
//    min - margin per axis, saturated. Intermediate vertices give no word.
//  - The last vertex passes the input reg, product reg and point reg in turn,
//    and the result word is then loaded into the result reg.
//  - Throughput: one vertex per cycle outside stalls, set by the nine 16x32
//    multipliers and the per-axis adder stage, all fully pipelined.
//  - Stall: while a result word waits on rsp_tready, non-final vertices keep
//    flowing; the pipeline holds only when a final vertex reaches the bounds
//    stage with the result register still full.
//  - Reset: matrix = identity, offsets = 0, margin = 6554 (about 0.1),
//    running bounds cleared, pipeline empty. csr_* writes are always ready
//    and must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module transformed_aabb_bounds (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // vertex input
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [95:0]                       req_tdata,  // vertex_x, vertex_y, vertex_z
   input  wire logic                              req_tlast,  // last_vertex
   // box output
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [191:0]                           rsp_tdata,  // upper_x, upper_y, upper_z,
                                                              // lower_x, lower_y, lower_z
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tab_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [tab_pkg::CsrDataW-1:0]      csr_wdata
);

   tab_pkg::xf_cfg_type                                      xf_cfg;
   tab_pkg::xf_out_type                                      xf_out;
   logic [tab_pkg::MarginW-1:0]                              margin;
   logic                                                     advance;
   logic [tab_pkg::NumAxes-1:0][tab_pkg::CoordW-1:0]         upper, lower;

   tab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .xf_cfg    (xf_cfg),
      .margin    (margin)
   );

   // whole front end moves together; ready is the advance enable
   assign req_tready = advance;

   tab_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_last   (req_tlast),
      .in_vertex (req_tdata),
      .xf_cfg    (xf_cfg),
      .xf_out    (xf_out)
   );

   tab_bounds u_bounds (
      .clock     (clock),
      .reset     (reset),
      .xf_out    (xf_out),
      .margin    (margin),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .upper     (upper),
      .lower     (lower)
   );

   assign rsp_tdata = {lower, upper};

endmodule
`default_nettype wire
